FILE: hw/rtl/mhsc_pkg.sv
// ----------------------------------------------------------------------------
// mhsc_pkg
// Shared types and constants of the minhash signature compare block.
// ----------------------------------------------------------------------------
package mhsc_pkg;

  localparam int ELEM_W     = 31;
  localparam int COEF_W     = 62;
  localparam int HIU_W      = 3;
  localparam int HIDX_OUT_W = 3;
  localparam int MATCH_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int COEF_REGS  = 5;

  // iterative remainder unit: 64-bit dividend, four bits per cycle
  localparam int DVD_W      = 64;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = DVD_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [CFG_IDX_W-1:0] REG_HASHES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 3'd1;
  localparam int                   REG_COEF0   = 2;

  localparam logic [HIU_W-1:0]  HASHES_RESET  = 3'd5;
  localparam logic [ELEM_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_RESET    = 62'h0000_0000_8000_0000;
  localparam logic [ELEM_W-1:0] MIN_RESET     = 31'h7FFF_FFFF;

  typedef struct packed {
    logic              cmd;
    logic [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic [HIDX_OUT_W-1:0] hash_index;
    logic [ELEM_W-1:0]     min_value;
    logic [MATCH_W-1:0]    match_count;
    logic                  reference_valid;
    logic                  range_error;
    logic                  last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_COMPARE,
    ST_LOAD,
    ST_SEND,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic latch_in;
    logic set_err;
    logic hash_clr;
    logic hash_inc;
    logic mul;
    logic mod_start;
    logic upd_min;
    logic compare;
    logic load_out;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic oor;
    logic fin;
    logic hash_last;
    logic out_last;
    logic mod_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/mhsc_stream_if.sv
// ----------------------------------------------------------------------------
// mhsc_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface mhsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/minhash_signature_compare.sv
// ----------------------------------------------------------------------------
// minhash_signature_compare
// An in-range element is hashed NUM_HASH times, with one shared multiplier
// and the iterative remainder unit; an out-of-range element skips the loop.
// A finishing item then compares, loads and sends one result per hash in
// use, and finishes. One item is worked on at a time.
// Reset clears minima to all ones, the error and reference flags, and loads
// the register defaults; the reference signature is written at each finish.
// ----------------------------------------------------------------------------
module minhash_signature_compare #(
  parameter int unsigned NUM_HASH = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mhsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mhsc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  mhsc_stream_if.sink                        in_if,
  mhsc_stream_if.source                      out_if
);
  import mhsc_pkg::*;

  logic [HIU_W-1:0]  hashes_q;
  logic [ELEM_W-1:0] modulus_q;
  logic [COEF_W-1:0] coef_q [COEF_REGS];
  logic [COEF_W-1:0] coef_hash [NUM_HASH];

  ctrl_cmd_t  cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hashes_q  <= HASHES_RESET;
      modulus_q <= MODULUS_RESET;
      for (int k = 0; k < COEF_REGS; k++) begin
        coef_q[k] <= COEF_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HASHES) begin
        hashes_q <= cfg_wdata_i[HIU_W-1:0];
      end
      if (cfg_idx_i == REG_MODULUS) begin
        modulus_q <= cfg_wdata_i[ELEM_W-1:0];
      end
      for (int k = 0; k < COEF_REGS; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_COEF0 + k)) begin
          coef_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  // hashes without a register keep the default coefficients
  for (genvar k = 0; k < NUM_HASH; k++) begin : g_coef
    if (k < COEF_REGS) begin : g_reg
      assign coef_hash[k] = coef_q[k];
    end else begin : g_fixed
      assign coef_hash[k] = COEF_RESET;
    end
  end

  mhsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid)
  );

  mhsc_datapath #(
    .NUM_HASH (NUM_HASH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_data_i       (in_if.data),
    .hashes_in_use_i (hashes_q),
    .modulus_i       (modulus_q),
    .coef_i          (coef_hash),
    .out_data_o      (out_if.data)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input taken while a result is pending");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second item accepted before the first was processed");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.data.last |=> !out_if.valid)
    else $error("result shown after the last one of a signature");

  a_match_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (!out_if.data.last || !out_if.data.reference_valid)
    |-> out_if.data.match_count == '0)
    else $error("match count outside the last result or without reference");

endmodule

FILE: hw/rtl/mhsc_mod_unit.sv
// ----------------------------------------------------------------------------
// mhsc_mod_unit
// Iterative restoring remainder, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module mhsc_mod_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mhsc_pkg::DVD_W-1:0]    dividend_i,
  input  logic [mhsc_pkg::ELEM_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [mhsc_pkg::ELEM_W-1:0]   rem_o
);
  import mhsc_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [ELEM_W-1:0]    rem_q, rem_d;

  always_comb begin
    logic [ELEM_W-1:0] r;
    logic [ELEM_W:0]   t;
    r = rem_q;
    for (int j = 0; j < DIV_STEPS; j++) begin
      t = {r, dvd_q[DVD_W-1-j]};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
      end
      r = t[ELEM_W-1:0];
    end
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = r;
      dvd_d = dvd_q << DIV_STEPS;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/mhsc_datapath.sv
// ----------------------------------------------------------------------------
// mhsc_datapath
// Hash arithmetic, running minima, reference signature and result register.
// ----------------------------------------------------------------------------
module mhsc_datapath #(
  parameter int unsigned NUM_HASH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhsc_pkg::ctrl_cmd_t           cmd_i,
  output mhsc_pkg::dp_status_t          status_o,
  input  mhsc_pkg::in_item_t            in_data_i,
  input  logic [mhsc_pkg::HIU_W-1:0]    hashes_in_use_i,
  input  logic [mhsc_pkg::ELEM_W-1:0]   modulus_i,
  input  logic [mhsc_pkg::COEF_W-1:0]   coef_i [NUM_HASH],
  output mhsc_pkg::out_item_t           out_data_o
);
  import mhsc_pkg::*;

  localparam int HIDX_W = (NUM_HASH > 1) ? $clog2(NUM_HASH) : 1;

  logic [ELEM_W-1:0]     elem_q;
  logic                  fin_q;
  logic [HIDX_W-1:0]     idx_q;
  logic [COEF_W-1:0]     prod_q;
  logic [ELEM_W-1:0]     min_q [NUM_HASH];
  logic [ELEM_W-1:0]     ref_q [NUM_HASH];
  logic                  present_q;
  logic                  err_q;
  logic [MATCH_W-1:0]    match_q, match_d;
  out_item_t             out_q;

  logic [COEF_W-1:0]     coef_sel;
  logic [ELEM_W-1:0]     a_sel, b_sel;
  logic [COEF_W-1:0]     prod_d;
  logic [COEF_W-1:0]     sum;
  logic [DVD_W-1:0]      dividend;
  logic [ELEM_W-1:0]     rem;
  logic                  mod_busy;
  logic [HIU_W-1:0]      act_last;

  assign coef_sel = coef_i[idx_q];
  assign a_sel    = coef_sel[COEF_W-1:ELEM_W];
  assign b_sel    = coef_sel[ELEM_W-1:0];
  assign prod_d   = a_sel * elem_q;
  assign sum      = prod_q + COEF_W'(b_sel);
  assign dividend = DVD_W'(sum);

  mhsc_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (dividend),
    .divisor_i  (modulus_i),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  // zero hashes acts as one, too many acts as all of them
  always_comb begin
    if (hashes_in_use_i == '0) begin
      act_last = '0;
    end else if (hashes_in_use_i > HIU_W'(NUM_HASH)) begin
      act_last = HIU_W'(NUM_HASH - 1);
    end else begin
      act_last = hashes_in_use_i - 1'b1;
    end
  end

  always_comb begin
    match_d = '0;
    for (int k = 0; k < NUM_HASH; k++) begin
      if (present_q && (HIU_W'(k) <= act_last) && (min_q[k] == ref_q[k])) begin
        match_d = match_d + 1'b1;
      end
    end
  end

  assign status_o.oor       = elem_q >= modulus_i;
  assign status_o.fin       = fin_q;
  assign status_o.hash_last = idx_q == HIDX_W'(NUM_HASH - 1);
  assign status_o.out_last  = HIU_W'(idx_q) == act_last;
  assign status_o.mod_busy  = mod_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      present_q <= 1'b0;
      err_q     <= 1'b0;
      for (int k = 0; k < NUM_HASH; k++) begin
        min_q[k] <= MIN_RESET;
      end
    end else begin
      if (cmd_i.hash_clr) begin
        idx_q <= '0;
      end else if (cmd_i.hash_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.upd_min && (rem < min_q[idx_q])) begin
        min_q[idx_q] <= rem;
      end
      if (cmd_i.finish) begin
        present_q <= 1'b1;
        err_q     <= 1'b0;
        for (int k = 0; k < NUM_HASH; k++) begin
          min_q[k] <= MIN_RESET;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      elem_q <= in_data_i.element;
      fin_q  <= in_data_i.cmd;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
    end
    if (cmd_i.finish) begin
      for (int k = 0; k < NUM_HASH; k++) begin
        ref_q[k] <= min_q[k];
      end
    end
    if (cmd_i.load_out) begin
      out_q.hash_index      <= HIDX_OUT_W'(idx_q);
      out_q.min_value       <= min_q[idx_q];
      out_q.match_count     <= status_o.out_last ? match_q : '0;
      out_q.reference_valid <= present_q;
      out_q.range_error     <= err_q;
      out_q.last            <= status_o.out_last;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/mhsc_ctrl.sv
// ----------------------------------------------------------------------------
// mhsc_ctrl
// Sequencer: hash loop per in-range element; a finishing item then gets compare and result emission.
// ----------------------------------------------------------------------------
module mhsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  input  mhsc_pkg::dp_status_t  status_i,
  output mhsc_pkg::ctrl_cmd_t   cmd_o,
  output logic                  in_ready_o,
  output logic                  out_valid_o
);
  import mhsc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.oor)     state_d = ST_MUL;
        else if (status_i.fin) state_d = ST_COMPARE;
        else                   state_d = ST_IDLE;
      end
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (!status_i.mod_busy) begin
          if (!status_i.hash_last) state_d = ST_MUL;
          else if (status_i.fin)   state_d = ST_COMPARE;
          else                     state_d = ST_IDLE;
        end
      end
      ST_COMPARE: state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_SEND;
      ST_SEND: begin
        if (out_ready_i) state_d = status_i.out_last ? ST_FINISH : ST_LOAD;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.set_err  = status_i.oor;
        cmd_o.hash_clr = 1'b1;
      end
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_START: cmd_o.mod_start = 1'b1;
      ST_DIV: begin
        cmd_o.upd_min  = !status_i.mod_busy;
        cmd_o.hash_inc = !status_i.mod_busy && !status_i.hash_last;
      end
      ST_COMPARE: begin
        cmd_o.compare  = 1'b1;
        cmd_o.hash_clr = 1'b1;
      end
      ST_LOAD: cmd_o.load_out = 1'b1;
      ST_SEND: begin
        out_valid_o    = 1'b1;
        cmd_o.hash_inc = out_ready_i && !status_i.out_last;
      end
      ST_FINISH: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

endmodule
